// ===== sv/mi4_pkg.sv =====
// Shared types, constants and index helpers for the 4x4 matrix inverse block.
package mi4_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W        = 32;
	localparam int IDX_W         = 4;
	localparam int NMAT          = 16;
	// Cofactor: six triple products of 32-bit signed values.
	localparam int ADJ_W         = 97;
	// Determinant: four products of an element and a cofactor.
	localparam int DET_W         = 130;
	localparam int LIMB_W        = 32;
	localparam int ADJ_LIMBS     = 4;
	localparam int MUL_W         = LIMB_W + 1;
	localparam int PROD_W        = 2 * MUL_W;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_RD0,
		S_RD1,
		S_RD2,
		S_MAB,
		S_MCL,
		S_MCH,
		S_ACH,
		S_ADJW,
		S_DRD,
		S_DLAT,
		S_DMUL,
		S_DACC,
		S_DET,
		S_ORD,
		S_OLAT,
		S_ODST,
		S_ODIV,
		S_OEMIT
	} state_t;

	typedef enum logic [2:0] {
		LAT_NONE,
		LAT_A,
		LAT_B,
		LAT_C,
		LAT_DET,
		LAT_ADJ
	} lat_t;

	typedef enum logic [1:0] {
		MUL_AB,
		MUL_CLO,
		MUL_CHI,
		MUL_LIMB
	} mul_t;

	typedef struct packed {
		logic       mat_we;
		idx_t       mat_waddr;
		idx_t       mat_raddr;
		logic       adj_we;
		idx_t       adj_waddr;
		idx_t       adj_raddr;
		lat_t       lat;
		logic       mul_en;
		mul_t       mul;
		logic [1:0] limb;
		logic       acc_clr;
		logic       acc_add;
		logic       acc_neg;
		logic       det_load;
		logic       div_start;
		logic       out_load;
		idx_t       out_index;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
		logic sing;
	} sts_t;

	typedef struct packed {
		idx_t a0;
		idx_t a1;
		idx_t a2;
		logic neg;
	} term_t;

	// Map position i of a 3x3 minor onto the 4x4 index, skipping s.
	function automatic logic [1:0] skip_idx(logic [1:0] i, logic [1:0] s);
		return (i >= s) ? i + 2'd1 : i;
	endfunction

	// Element addresses and sign of triple product t of cofactor k.
	// The minor drops row (k mod 4) and column (k div 4): transposed adjugate.
	function automatic term_t term_sel(idx_t k, logic [2:0] t);
		logic [1:0] r;
		logic [1:0] c;
		logic [1:0] p0;
		logic [1:0] p1;
		logic [1:0] p2;
		logic       ps;
		term_t      res;
		r = k[3:2];
		c = k[1:0];
		case (t)
			3'd1:    begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; ps = 1'b1; end
			3'd2:    begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; ps = 1'b1; end
			3'd3:    begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; ps = 1'b0; end
			3'd4:    begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; ps = 1'b0; end
			3'd5:    begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; ps = 1'b1; end
			default: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; ps = 1'b0; end
		endcase
		res.a0  = {skip_idx(2'd0, c), skip_idx(p0, r)};
		res.a1  = {skip_idx(2'd1, c), skip_idx(p1, r)};
		res.a2  = {skip_idx(2'd2, c), skip_idx(p2, r)};
		res.neg = ps ^ r[0] ^ c[0];
		return res;
	endfunction

endpackage

// ===== sv/mi4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mi4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/mi4_ctrl.sv =====
// Sequencer for load, cofactor, determinant and divide/emit phases.
module mi4_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mi4_pkg::sts_t sts,
	output mi4_pkg::cmd_t cmd
);
	import mi4_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	idx_t       load_q;
	idx_t       k_q;
	logic [2:0] t_q;
	logic [1:0] limb_q;
	term_t      term;

	assign term = term_sel(k_q, t_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			load_q  <= '0;
			k_q     <= '0;
			t_q     <= '0;
			limb_q  <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						load_q <= load_q + 1'b1;
					end
				end
				S_ACH: begin
					t_q <= (t_q == 3'd5) ? 3'd0 : t_q + 3'd1;
				end
				S_ADJW: begin
					k_q <= k_q + 1'b1;
				end
				S_DLAT: begin
					limb_q <= '0;
				end
				S_DACC: begin
					limb_q <= limb_q + 1'b1;
					if (limb_q == 2'd3) begin
						k_q <= (k_q == idx_t'(3)) ? '0 : k_q + 1'b1;
					end
				end
				S_OEMIT: begin
					if (sts.out_free) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_valid && load_q == idx_t'(NMAT - 1)) begin
					state_nxt = S_RD0;
				end
			end
			S_RD0:  state_nxt = S_RD1;
			S_RD1:  state_nxt = S_RD2;
			S_RD2:  state_nxt = S_MAB;
			S_MAB:  state_nxt = S_MCL;
			S_MCL:  state_nxt = S_MCH;
			S_MCH:  state_nxt = S_ACH;
			S_ACH:  state_nxt = (t_q == 3'd5) ? S_ADJW : S_RD0;
			S_ADJW: state_nxt = (k_q == idx_t'(NMAT - 1)) ? S_DRD : S_RD0;
			S_DRD:  state_nxt = S_DLAT;
			S_DLAT: state_nxt = S_DMUL;
			S_DMUL: state_nxt = S_DACC;
			S_DACC: begin
				if (limb_q != 2'd3) begin
					state_nxt = S_DMUL;
				end else if (k_q == idx_t'(3)) begin
					state_nxt = S_DET;
				end else begin
					state_nxt = S_DRD;
				end
			end
			S_DET:  state_nxt = S_ORD;
			S_ORD:  state_nxt = S_OLAT;
			S_OLAT: state_nxt = sts.sing ? S_OEMIT : S_ODST;
			S_ODST: state_nxt = S_ODIV;
			S_ODIV: begin
				if (!sts.div_busy) begin
					state_nxt = S_OEMIT;
				end
			end
			S_OEMIT: begin
				if (sts.out_free) begin
					state_nxt = (k_q == idx_t'(NMAT - 1)) ? S_LOAD : S_ORD;
				end
			end
			default: state_nxt = S_LOAD;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.lat       = LAT_NONE;
		cmd.mul       = MUL_AB;
		cmd.out_index = k_q;
		in_ready      = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready      = 1'b1;
				cmd.mat_we    = in_valid;
				cmd.mat_waddr = load_q;
				cmd.acc_clr   = 1'b1;
			end
			S_RD0: cmd.mat_raddr = term.a0;
			S_RD1: begin
				cmd.lat       = LAT_A;
				cmd.mat_raddr = term.a1;
			end
			S_RD2: begin
				cmd.lat       = LAT_B;
				cmd.mat_raddr = term.a2;
			end
			S_MAB: begin
				cmd.lat    = LAT_C;
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_AB;
			end
			S_MCL: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_CLO;
			end
			S_MCH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul     = MUL_CHI;
				cmd.acc_add = 1'b1;
				cmd.acc_neg = term.neg;
				cmd.limb    = 2'd0;
			end
			S_ACH: begin
				cmd.acc_add = 1'b1;
				cmd.acc_neg = term.neg;
				cmd.limb    = 2'd1;
			end
			S_ADJW: begin
				cmd.adj_we    = 1'b1;
				cmd.adj_waddr = k_q;
				cmd.acc_clr   = 1'b1;
			end
			S_DRD: begin
				cmd.mat_raddr = {2'b00, k_q[1:0]};
				cmd.adj_raddr = {k_q[1:0], 2'b00};
			end
			S_DLAT: cmd.lat = LAT_DET;
			S_DMUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_LIMB;
				cmd.limb   = limb_q;
			end
			S_DACC: begin
				cmd.acc_add = 1'b1;
				cmd.limb    = limb_q;
			end
			S_DET:   cmd.det_load  = 1'b1;
			S_ORD:   cmd.adj_raddr = k_q;
			S_OLAT:  cmd.lat       = LAT_ADJ;
			S_ODST:  cmd.div_start = 1'b1;
			S_OEMIT: cmd.out_load  = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/mi4_dp.sv =====
// Datapath: matrix and cofactor stores, shared multiplier, accumulator, divider, output register.
module mi4_dp #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mi4_pkg::cmd_t                     cmd,
	output mi4_pkg::sts_t                     sts,
	input  logic signed [mi4_pkg::ELEM_W-1:0] element_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mi4_pkg::ELEM_W-1:0] inverse_value,
	output logic [mi4_pkg::IDX_W-1:0]         out_index,
	output logic                              last_of_run,
	output logic                              singular
);
	import mi4_pkg::*;

	localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int PAD_W = ADJ_LIMBS * LIMB_W;

	logic [ELEM_W-1:0]        mat_rdata;
	logic [ADJ_W-1:0]         adj_rdata;
	logic signed [ELEM_W-1:0] a_q;
	logic signed [ELEM_W-1:0] b_q;
	logic signed [ELEM_W-1:0] c_q;
	logic signed [ADJ_W-1:0]  adjv_q;
	logic [2*LIMB_W-1:0]      p_q;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DET_W-1:0]  acc_q;
	logic signed [DET_W-1:0]  prod_ext;
	logic signed [DET_W-1:0]  addend;
	logic signed [PAD_W-1:0]  adj_pad;
	logic [LIMB_W-1:0]        limb_bits;

	logic [DET_W-1:0]         dmag_q;
	logic                     det_neg_q;
	logic                     sing_q;
	logic [NUM_W-1:0]         num_q;
	logic [DET_W-1:0]         rem_q;
	logic [LIMB_W:0]          quo_q;
	logic                     ovf_q;
	logic                     res_neg_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic [DET_W:0]           trial;
	logic                     fits;
	logic [ADJ_W-1:0]         adj_mag;
	logic [ELEM_W-1:0]        result;

	mi4_ram #(.WIDTH(ELEM_W), .DEPTH(NMAT)) u_mat (
		.clk   (clk),
		.we    (cmd.mat_we),
		.waddr (cmd.mat_waddr),
		.wdata (element_value),
		.raddr (cmd.mat_raddr),
		.rdata (mat_rdata)
	);

	mi4_ram #(.WIDTH(ADJ_W), .DEPTH(NMAT)) u_adj (
		.clk   (clk),
		.we    (cmd.adj_we),
		.waddr (cmd.adj_waddr),
		.wdata (acc_q[ADJ_W-1:0]),
		.raddr (cmd.adj_raddr),
		.rdata (adj_rdata)
	);

	// Operand latches
	always_ff @(posedge clk) begin
		case (cmd.lat)
			LAT_A:   a_q <= mat_rdata;
			LAT_B:   b_q <= mat_rdata;
			LAT_C:   c_q <= mat_rdata;
			LAT_DET: begin
				a_q    <= mat_rdata;
				adjv_q <= adj_rdata;
			end
			LAT_ADJ: adjv_q <= adj_rdata;
			default: begin
			end
		endcase
	end

	assign adj_pad   = PAD_W'(adjv_q);
	assign limb_bits = adj_pad[cmd.limb * LIMB_W +: LIMB_W];

	always_comb begin
		case (cmd.mul)
			MUL_AB: begin
				mul_a = MUL_W'(a_q);
				mul_b = MUL_W'(b_q);
			end
			MUL_CLO: begin
				mul_a = MUL_W'(c_q);
				mul_b = {1'b0, prod_q[LIMB_W-1:0]};
			end
			MUL_CHI: begin
				mul_a = MUL_W'(c_q);
				mul_b = {p_q[2*LIMB_W-1], p_q[2*LIMB_W-1:LIMB_W]};
			end
			MUL_LIMB: begin
				mul_a = MUL_W'(a_q);
				mul_b = (cmd.limb == 2'(ADJ_LIMBS - 1)) ? {limb_bits[LIMB_W-1], limb_bits}
				                                         : {1'b0, limb_bits};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared multiplier; keep the pair product while its halves are used.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
			if (cmd.mul == MUL_CLO) begin
				p_q <= prod_q[2*LIMB_W-1:0];
			end
		end
	end

	assign prod_ext = DET_W'(prod_q);

	always_comb begin
		case (cmd.limb)
			2'd1:    addend = prod_ext <<< LIMB_W;
			2'd2:    addend = prod_ext <<< (2 * LIMB_W);
			2'd3:    addend = prod_ext <<< (3 * LIMB_W);
			default: addend = prod_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= cmd.acc_neg ? acc_q - addend : acc_q + addend;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.det_load) begin
			det_neg_q <= acc_q[DET_W-1];
			dmag_q    <= acc_q[DET_W-1] ? DET_W'(-acc_q) : DET_W'(acc_q);
			sing_q    <= (acc_q == '0);
		end
	end

	// Restoring divider, one quotient bit per cycle
	assign adj_mag = adjv_q[ADJ_W-1] ? ADJ_W'(-adjv_q) : ADJ_W'(adjv_q);
	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign fits    = (trial >= {1'b0, dmag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q     <= {adj_mag, {(2 * FRAC_BITS){1'b0}}};
			rem_q     <= '0;
			quo_q     <= '0;
			ovf_q     <= 1'b0;
			res_neg_q <= adjv_q[ADJ_W-1] ^ det_neg_q;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? DET_W'(trial - {1'b0, dmag_q}) : trial[DET_W-1:0];
			quo_q <= {quo_q[LIMB_W-1:0], fits};
			ovf_q <= ovf_q | quo_q[LIMB_W];
		end
	end

	// Truncated quotient, saturated to the element range; zero when singular
	always_comb begin
		if (sing_q) begin
			result = '0;
		end else if (res_neg_q) begin
			result = (ovf_q || quo_q > {1'b0, 1'b1, {(LIMB_W - 1){1'b0}}})
			         ? {1'b1, {(ELEM_W - 1){1'b0}}} : ELEM_W'(-quo_q);
		end else begin
			result = (ovf_q || quo_q[LIMB_W] || quo_q[LIMB_W-1])
			         ? {1'b0, {(ELEM_W - 1){1'b1}}} : quo_q[ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			inverse_value <= result;
			out_index     <= cmd.out_index;
			last_of_run   <= (cmd.out_index == idx_t'(NMAT - 1));
			singular      <= sing_q;
		end
	end

	assign sts.div_busy = busy_q;
	assign sts.out_free = !out_valid || out_ready;
	assign sts.sing     = sing_q;

endmodule

// ===== sv/matrix_inverse_4x4.sv =====
// Top level of the 4x4 fixed-point matrix inverse (adjugate over determinant).
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------------
//   in       | in_valid / in_ready | element_value
//   out      | out_valid/out_ready | inverse_value, out_index, last_of_run, singular
//
// Flow: the block takes one element per cycle while loading; after the sixteenth,
// the cofactors are computed on the shared 33x33 multiplier, then the determinant,
// then each result passes through the bit-serial divider, which is skipped
// when the matrix is singular.
// Reset: arst_n clears the sequencer, the load count and the output valid.
// Stalls: out_ready low holds the output register and the sequencer; in_ready
// is high only while loading.
module matrix_inverse_4x4 #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [mi4_pkg::ELEM_W-1:0] element_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mi4_pkg::ELEM_W-1:0] inverse_value,
	output logic [mi4_pkg::IDX_W-1:0]         out_index,
	output logic                              last_of_run,
	output logic                              singular
);
	import mi4_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: drive loads, cofactor terms, determinant limbs and divides
	mi4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: hold the matrix and cofactors, multiply, accumulate, divide
	mi4_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.inverse_value (inverse_value),
		.out_index     (out_index),
		.last_of_run   (last_of_run),
		.singular      (singular)
	);

endmodule
